FILE: src/bte_pkg.sv
// Shared types and constants for the blow-through envelope.
// No dependencies; imported by every module of the block.
package bte_pkg;

    localparam int TIME_BITS_DEF = 48;

    localparam int PROX_W     = 16;
    localparam int DRIVE_W    = 17;
    localparam int CUE_W      = 16;
    localparam int DUR_W      = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Mul/div unit: multiplicand x duration-sized multiplier, quotient fits QUO_W.
    localparam int MCAND_W = 17;
    localparam int QUO_W   = 17;
    localparam int PROD_W  = MCAND_W + DUR_W;

    // Register indexes on the config port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIP        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIP_TIME   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 4'd7;

    // Register reset values.
    localparam logic [PROX_W-1:0]         RST_THRESHOLD  = 16'd16384;
    localparam logic [PROX_W-1:0]         RST_SATURATION = 16'd32768;
    localparam logic [CUE_W-1:0]          RST_PEAK       = 16'd25600;
    localparam logic signed [DRIVE_W-1:0] RST_DIP        = -17'sd12800;
    localparam logic [DUR_W-1:0]          RST_HOLD       = 24'd50000;
    localparam logic [DUR_W-1:0]          RST_DIP_TIME   = 24'd50000;
    localparam logic [DUR_W-1:0]          RST_RECOVER    = 24'd100000;
    localparam logic [DUR_W-1:0]          RST_REFRACTORY = 24'd1000000;

    // Request into the shared multiply-divide unit: computes mcand * mplier / divisor.
    typedef struct packed {
        logic               start;
        logic [MCAND_W-1:0] mcand;
        logic [DUR_W-1:0]   mplier;
        logic [DUR_W-1:0]   divisor;
    } md_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } md_rsp_t;

endpackage

FILE: src/bte_muldiv.sv
// Shared iterative multiply-then-divide unit: one multiply step, then one
// restoring-division step per cycle. Depends on bte_pkg.
module bte_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  bte_pkg::md_req_t  req,
    output bte_pkg::md_rsp_t  rsp
);
    import bte_pkg::*;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    localparam int CNT_W = $clog2(QUO_W + 1);

    md_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [DUR_W-1:0]   mplier_reg, mplier_next;
    logic [DUR_W-1:0]   divisor_reg, divisor_next;
    logic [DUR_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   shq_reg, shq_next;   // dividend low bits in, quotient bits out

    logic [PROD_W-1:0]  product;
    logic [DUR_W:0]     trial;
    logic [DUR_W:0]     diff;
    logic               ge;

    assign product = mcand_reg * mplier_reg;
    assign trial   = {rem_reg, shq_reg[QUO_W-1]};
    assign diff    = trial - {1'b0, divisor_reg};
    assign ge      = (trial >= {1'b0, divisor_reg});

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        shq_next     = shq_reg;
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    mcand_next   = req.mcand;
                    mplier_next  = req.mplier;
                    divisor_next = req.divisor;
                    state_next   = MD_MUL;
                end
            end
            MD_MUL: begin
                // quotient < 2^QUO_W, so the upper product bits are already below divisor
                rem_next   = product[PROD_W-1:QUO_W];
                shq_next   = product[QUO_W-1:0];
                cnt_next   = CNT_W'(QUO_W);
                state_next = MD_DIV;
            end
            MD_DIV: begin
                rem_next = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
                shq_next = {shq_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        shq_reg     <= shq_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = shq_reg;

endmodule

FILE: src/blow_through_envelope_top.sv
// Blow-through envelope top level: config registers, phase state, sequencer.
// Depends on bte_pkg and bte_muldiv.
//
// Haptic burn-through envelope. Each transfer on the s_ channel is one control
// tick (time in us, Q1.15 proximity, Q8.8 live speed cue) and yields exactly one
// transfer on the m_ channel (signed Q8.8 blow drive, gated speed cue). In idle
// the drive ramps from zero at the threshold toward the peak at saturation;
// reaching saturation latches time and cue and runs hold, peak-to-dip ramp
// (cue silent) and recovery (cue fading back), after which the block is locked
// out until refractory_time from the latch has passed and proximity is back
// below threshold. Ticks are handled one at a time and s_ready is low while a
// tick is in work. Ticks that need no scaling bypass the multiply-divide unit;
// the approach and dip ramps use the single shared unit once and recovery uses
// it twice (one multiply step plus 17 restoring-division steps per use). The
// next tick can be accepted in the cycle after the result is registered. A
// finished result sits in the output register while the next tick is accepted;
// the sequencer stalls only if a second result is ready before the first is
// taken. Config writes (cfg_ port, always ready) must only be issued while the
// block is idle; indexes beyond the list are ignored.
module blow_through_envelope_top #(
    parameter int TIME_BITS = bte_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input ticks
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [TIME_BITS-1:0]                s_now_us,
    input  logic [bte_pkg::PROX_W-1:0]          s_proximity,
    input  logic [bte_pkg::CUE_W-1:0]           s_live_speed_cue,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bte_pkg::DRIVE_W-1:0]  m_blow_drive,
    output logic [bte_pkg::CUE_W-1:0]           m_speed_cue_out,
    // config writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bte_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bte_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bte_pkg::*;

    // Sum of up to three durations.
    localparam int T_W = DUR_W + 2;
    // Signed working width for drive arithmetic.
    localparam int W_W = DRIVE_W + 2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TAU    = 6'b000010,
        S_DECIDE = 6'b000100,
        S_WAIT1  = 6'b001000,
        S_WAIT2  = 6'b010000,
        S_DONE   = 6'b100000
    } seq_state_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_FIRING  = 3'b010,
        PH_REFRACT = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        OP_APPR = 3'b001,
        OP_DIP  = 3'b010,
        OP_REC  = 3'b100
    } op_t;

    // ---------------- config registers ----------------
    logic [PROX_W-1:0]         thr_reg;
    logic [PROX_W-1:0]         sat_reg;
    logic [CUE_W-1:0]          peak_reg;
    logic signed [DRIVE_W-1:0] dip_reg;
    logic [DUR_W-1:0]          hold_reg;
    logic [DUR_W-1:0]          dip_time_reg;
    logic [DUR_W-1:0]          rec_reg;
    logic [DUR_W-1:0]          refr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= RST_THRESHOLD;
            sat_reg      <= RST_SATURATION;
            peak_reg     <= RST_PEAK;
            dip_reg      <= RST_DIP;
            hold_reg     <= RST_HOLD;
            dip_time_reg <= RST_DIP_TIME;
            rec_reg      <= RST_RECOVER;
            refr_reg     <= RST_REFRACTORY;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_THRESHOLD:  thr_reg      <= cfg_data[PROX_W-1:0];
                REG_SATURATION: sat_reg      <= cfg_data[PROX_W-1:0];
                REG_PEAK:       peak_reg     <= cfg_data[CUE_W-1:0];
                REG_DIP:        dip_reg      <= cfg_data[DRIVE_W-1:0];
                REG_HOLD:       hold_reg     <= cfg_data[DUR_W-1:0];
                REG_DIP_TIME:   dip_time_reg <= cfg_data[DUR_W-1:0];
                REG_RECOVER:    rec_reg      <= cfg_data[DUR_W-1:0];
                REG_REFRACTORY: refr_reg     <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    seq_state_t                state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [TIME_BITS-1:0]      latch_reg, latch_next;
    logic [CUE_W-1:0]          frozen_reg, frozen_next;
    op_t                       op_reg, op_next;
    logic                      neg_reg, neg_next;

    logic [TIME_BITS-1:0]      now_reg, now_next;
    logic [PROX_W-1:0]         prox_reg, prox_next;
    logic [CUE_W-1:0]          live_reg, live_next;
    logic [TIME_BITS-1:0]      tau_reg, tau_next;
    logic [T_W-1:0]            t1_reg, t1_next;
    logic [T_W-1:0]            t2_reg, t2_next;
    logic [T_W-1:0]            t3_reg, t3_next;
    logic [DUR_W-1:0]          e_reg, e_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic [CUE_W-1:0]          cue_reg, cue_next;

    logic                      m_valid_reg, m_valid_next;
    logic signed [DRIVE_W-1:0] m_drive_reg, m_drive_next;
    logic [CUE_W-1:0]          m_cue_reg, m_cue_next;

    md_req_t                   md_req;
    md_rsp_t                   md_rsp;

    bte_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    // ---------------- datapath helpers ----------------
    logic signed [W_W-1:0] dip_w;
    logic signed [W_W-1:0] peak_w;
    logic signed [W_W-1:0] dip_minus_peak;
    logic signed [W_W-1:0] dmp_abs;
    logic signed [W_W-1:0] dip_abs;
    logic signed [W_W-1:0] quot_w;
    logic signed [W_W-1:0] quot_signed;
    logic [T_W-1:0]        e_dip;
    logic [T_W-1:0]        e_rec;

    assign dip_w          = W_W'(dip_reg);
    assign peak_w         = W_W'(signed'({1'b0, peak_reg}));
    assign dip_minus_peak = dip_w - peak_w;
    assign dmp_abs        = dip_minus_peak[W_W-1] ? -dip_minus_peak : dip_minus_peak;
    assign dip_abs        = dip_w[W_W-1] ? -dip_w : dip_w;
    assign quot_w         = W_W'(signed'({1'b0, md_rsp.quot}));
    assign quot_signed    = neg_reg ? -quot_w : quot_w;
    // tau is below t2 (resp. t3) where these are used, so the low bits suffice
    assign e_dip          = tau_reg[T_W-1:0] - t1_reg;
    assign e_rec          = tau_reg[T_W-1:0] - t2_reg;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        latch_next   = latch_reg;
        frozen_next  = frozen_reg;
        op_next      = op_reg;
        neg_next     = neg_reg;
        now_next     = now_reg;
        prox_next    = prox_reg;
        live_next    = live_reg;
        tau_next     = tau_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        t3_next      = t3_reg;
        e_next       = e_reg;
        drive_next   = drive_reg;
        cue_next     = cue_reg;
        m_valid_next = m_valid_reg;
        m_drive_next = m_drive_reg;
        m_cue_next   = m_cue_reg;
        md_req       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    now_next   = s_now_us;
                    prox_next  = s_proximity;
                    live_next  = s_live_speed_cue;
                    state_next = S_TAU;
                end
            end
            S_TAU: begin
                // elapsed time wraps modulo 2^TIME_BITS
                tau_next   = now_reg - latch_reg;
                t1_next    = T_W'(hold_reg);
                t2_next    = T_W'(hold_reg) + T_W'(dip_time_reg);
                t3_next    = T_W'(hold_reg) + T_W'(dip_time_reg) + T_W'(rec_reg);
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_DONE;
                drive_next = '0;
                cue_next   = live_reg;
                case (phase_reg)
                    PH_FIRING: begin
                        if (tau_reg < TIME_BITS'(t1_reg)) begin
                            drive_next = DRIVE_W'(peak_w);
                            cue_next   = frozen_reg;
                        end else if (tau_reg < TIME_BITS'(t2_reg)) begin
                            md_req.start   = 1'b1;
                            md_req.mcand   = dmp_abs[MCAND_W-1:0];
                            md_req.mplier  = e_dip[DUR_W-1:0];
                            md_req.divisor = dip_time_reg;
                            neg_next       = dip_minus_peak[W_W-1];
                            op_next        = OP_DIP;
                            state_next     = S_WAIT1;
                        end else if (tau_reg < TIME_BITS'(t3_reg)) begin
                            md_req.start   = 1'b1;
                            md_req.mcand   = dip_abs[MCAND_W-1:0];
                            md_req.mplier  = rec_reg - e_rec[DUR_W-1:0];
                            md_req.divisor = rec_reg;
                            e_next         = e_rec[DUR_W-1:0];
                            neg_next       = dip_w[W_W-1];
                            op_next        = OP_REC;
                            state_next     = S_WAIT1;
                        end else begin
                            phase_next = PH_REFRACT;
                        end
                    end
                    PH_REFRACT: begin
                        if (tau_reg >= TIME_BITS'(refr_reg) && prox_reg < thr_reg) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        if (prox_reg >= sat_reg) begin
                            phase_next  = PH_FIRING;
                            latch_next  = now_reg;
                            frozen_next = live_reg;
                            drive_next  = DRIVE_W'(peak_w);
                        end else if (prox_reg > thr_reg) begin
                            md_req.start   = 1'b1;
                            md_req.mcand   = MCAND_W'(peak_reg);
                            md_req.mplier  = DUR_W'(prox_reg - thr_reg);
                            md_req.divisor = DUR_W'(sat_reg - thr_reg);
                            neg_next       = 1'b0;
                            op_next        = OP_APPR;
                            state_next     = S_WAIT1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            S_WAIT1: begin
                if (md_rsp.done) begin
                    state_next = S_DONE;
                    case (op_reg)
                        OP_DIP: begin
                            drive_next = DRIVE_W'(peak_w + quot_signed);
                            cue_next   = '0;
                        end
                        OP_REC: begin
                            drive_next     = DRIVE_W'(quot_signed);
                            // cue fades back in: live * e / recover_time
                            md_req.start   = 1'b1;
                            md_req.mcand   = MCAND_W'(live_reg);
                            md_req.mplier  = e_reg;
                            md_req.divisor = rec_reg;
                            state_next     = S_WAIT2;
                        end
                        default: begin
                            drive_next = DRIVE_W'(quot_w);
                            cue_next   = live_reg;
                        end
                    endcase
                end
            end
            S_WAIT2: begin
                if (md_rsp.done) begin
                    cue_next   = md_rsp.quot[CUE_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_drive_next = drive_reg;
                    m_cue_next   = cue_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_IDLE;
            latch_reg   <= '0;
            frozen_reg  <= '0;
            m_valid_reg <= 1'b0;
            op_reg      <= OP_APPR;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            latch_reg   <= latch_next;
            frozen_reg  <= frozen_next;
            m_valid_reg <= m_valid_next;
            op_reg      <= op_next;
            neg_reg     <= neg_next;
        end
        now_reg     <= now_next;
        prox_reg    <= prox_next;
        live_reg    <= live_next;
        tau_reg     <= tau_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        e_reg       <= e_next;
        drive_reg   <= drive_next;
        cue_reg     <= cue_next;
        m_drive_reg <= m_drive_next;
        m_cue_reg   <= m_cue_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_blow_drive    = m_drive_reg;
    assign m_speed_cue_out = m_cue_reg;

endmodule

FILE: src/bte_checker.sv
// Port-level checks for the blow-through envelope, bound to the top level.
// Depends on bte_pkg and blow_through_envelope_top.
module bte_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [bte_pkg::DRIVE_W-1:0]  m_blow_drive,
    input logic [bte_pkg::CUE_W-1:0]           m_speed_cue_out,
    input logic                                cfg_ready
);
    import bte_pkg::*;

    // one tick in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a tick is in work");

    // a new result only comes out of the finishing step, where input is held off
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a finishing step");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_blow_drive) && $stable(m_speed_cue_out)))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind blow_through_envelope_top bte_checker u_bte_checker (.*);

FILE: tb/sv/blow_through_envelope_checker.sv
// Scoreboard for the blow-through envelope: predicts every result from the
// observed tick and config transfers and compares it with the m_ channel.
// Depends on bte_pkg; instantiated beside the block by the testbench top.
module blow_through_envelope_checker #(
    parameter int TIME_BITS = bte_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [TIME_BITS-1:0]                s_now_us,
    input  logic [bte_pkg::PROX_W-1:0]          s_proximity,
    input  logic [bte_pkg::CUE_W-1:0]           s_live_speed_cue,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [bte_pkg::DRIVE_W-1:0]  m_blow_drive,
    input  logic [bte_pkg::CUE_W-1:0]           m_speed_cue_out,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bte_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bte_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  results_seen,
    output int                                  pending
);
    import bte_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FIRING  = 2'd1,
        PH_REFRACT = 2'd2
    } env_phase_e;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic [CUE_W-1:0]          cue;
    } envelope_t;

    // register copies
    logic [PROX_W-1:0]         thr_cfg, sat_cfg;
    logic [CUE_W-1:0]          peak_cfg;
    logic signed [DRIVE_W-1:0] dip_cfg;
    logic [DUR_W-1:0]          hold_cfg, dip_len_cfg, recover_cfg, refract_cfg;

    // envelope state
    env_phase_e                env_phase;
    logic [TIME_BITS-1:0]      latched_at;
    logic [CUE_W-1:0]          held_cue;

    envelope_t envelopes_due[$];
    int fails = 0;
    int seen  = 0;

    initial begin
        fail_count   = 0;
        results_seen = 0;
        pending      = 0;
    end

    // Advances the envelope by one tick and returns the drive and cue it yields.
    function automatic envelope_t step_envelope(input logic [TIME_BITS-1:0] now,
                                                input logic [PROX_W-1:0] prox,
                                                input logic [CUE_W-1:0] live);
        logic [TIME_BITS-1:0] tau;
        longint tau_l, t1, t2, t3, e, drv, cue_l;
        longint peak_l, dip_l, dip_len_l, rec_l, live_l, prox_l, thr_l, sat_l;
        envelope_t res;
        tau       = now - latched_at;   // wraps, so time going back reads as very long
        tau_l     = tau;
        peak_l    = peak_cfg;
        dip_l     = dip_cfg;
        dip_len_l = dip_len_cfg;
        rec_l     = recover_cfg;
        live_l    = live;
        prox_l    = prox;
        thr_l     = thr_cfg;
        sat_l     = sat_cfg;
        drv       = 0;
        cue_l     = live_l;
        case (env_phase)
            PH_FIRING: begin
                t1 = hold_cfg;
                t2 = t1 + dip_len_l;
                t3 = t2 + rec_l;
                if (tau_l < t1) begin
                    drv   = peak_l;
                    cue_l = held_cue;
                end else if (tau_l < t2) begin
                    e     = tau_l - t1;
                    drv   = peak_l + ((dip_l - peak_l) * e) / dip_len_l;
                    cue_l = 0;
                end else if (tau_l < t3) begin
                    e     = tau_l - t2;
                    drv   = (dip_l * (rec_l - e)) / rec_l;
                    cue_l = (live_l * e) / rec_l;
                end else begin
                    env_phase = PH_REFRACT;
                end
            end
            PH_REFRACT: begin
                if (tau_l >= longint'(refract_cfg) && prox_l < thr_l)
                    env_phase = PH_IDLE;
            end
            PH_IDLE: begin
                // fire test first: saturation at or below threshold never divides
                if (prox_l >= sat_l) begin
                    env_phase  = PH_FIRING;
                    latched_at = now;
                    held_cue   = live;
                    drv        = peak_l;
                end else if (prox_l > thr_l) begin
                    drv = (peak_l * (prox_l - thr_l)) / (sat_l - thr_l);
                end
            end
            default: env_phase = PH_IDLE;
        endcase
        res.drive = drv[DRIVE_W-1:0];
        res.cue   = cue_l[CUE_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        envelope_t got, want;
        if (!aresetn) begin
            thr_cfg     = RST_THRESHOLD;
            sat_cfg     = RST_SATURATION;
            peak_cfg    = RST_PEAK;
            dip_cfg     = RST_DIP;
            hold_cfg    = RST_HOLD;
            dip_len_cfg = RST_DIP_TIME;
            recover_cfg = RST_RECOVER;
            refract_cfg = RST_REFRACTORY;
            env_phase   = PH_IDLE;
            latched_at  = '0;
            held_cue    = '0;
            envelopes_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD:  thr_cfg     = cfg_data[PROX_W-1:0];
                    REG_SATURATION: sat_cfg     = cfg_data[PROX_W-1:0];
                    REG_PEAK:       peak_cfg    = cfg_data[CUE_W-1:0];
                    REG_DIP:        dip_cfg     = cfg_data[DRIVE_W-1:0];
                    REG_HOLD:       hold_cfg    = cfg_data[DUR_W-1:0];
                    REG_DIP_TIME:   dip_len_cfg = cfg_data[DUR_W-1:0];
                    REG_RECOVER:    recover_cfg = cfg_data[DUR_W-1:0];
                    REG_REFRACTORY: refract_cfg = cfg_data[DUR_W-1:0];
                    default: ;
                endcase
            end
            // compare before pushing, so a result never matches its own tick
            if (m_valid && m_ready) begin
                got.drive = m_blow_drive;
                got.cue   = m_speed_cue_out;
                seen++;
                if (envelopes_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result: drive %0d cue %0d",
                                 got.drive, got.cue);
                end else begin
                    want = envelopes_due.pop_front();
                    if (got.drive !== want.drive || got.cue !== want.cue) begin
                        fails++;
                        if (fails <= 10)
                            $display("result %0d: expected drive %0d cue %0d, got drive %0d cue %0d",
                                     seen, want.drive, want.cue, got.drive, got.cue);
                    end
                end
            end
            if (s_valid && s_ready)
                envelopes_due.push_back(step_envelope(s_now_us, s_proximity,
                                                      s_live_speed_cue));
        end
        fail_count   <= fails;
        results_seen <= seen;
        pending      <= envelopes_due.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the blow-through envelope testbench: clock, reset, tick and config
// stimulus, result back-pressure and the verdict.
// Depends on bte_pkg, blow_through_envelope_top and blow_through_envelope_checker.
module testbench;
    import bte_pkg::*;

    localparam int TB_TIME_BITS    = TIME_BITS_DEF;
    localparam int REG_COUNT       = 8;
    localparam int SETTINGS_RUN    = 8;       // config settings in the random part
    localparam int TICKS_PER_SET   = 190;
    localparam int RESET_SETTING   = -1;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int TAIL_CYCLES     = 60;      // a bit over the slowest tick latency
    localparam logic [TB_TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct {
        logic [PROX_W-1:0]         thr;
        logic [PROX_W-1:0]         sat;
        logic [CUE_W-1:0]          peak;
        logic signed [DRIVE_W-1:0] dip;
        logic [DUR_W-1:0]          hold;
        logic [DUR_W-1:0]          dip_len;
        logic [DUR_W-1:0]          recover;
        logic [DUR_W-1:0]          refract;
    } envelope_cfg_t;

    typedef enum {ALWAYS_READY, COIN_FLIP, LONG_RUNS} ready_mode_e;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid          = 1'b0;
    logic                        s_ready;
    logic [TB_TIME_BITS-1:0]     s_now_us         = '0;
    logic [PROX_W-1:0]           s_proximity      = '0;
    logic [CUE_W-1:0]            s_live_speed_cue = '0;

    logic                        m_valid;
    logic                        m_ready          = 1'b1;
    logic signed [DRIVE_W-1:0]   m_blow_drive;
    logic [CUE_W-1:0]            m_speed_cue_out;

    logic                        cfg_valid        = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index        = '0;
    logic [CFG_DATA_W-1:0]       cfg_data         = '0;

    int fail_count;
    int results_seen;
    int pending;

    int          ticks_sent  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    ready_mode_e ready_mode  = ALWAYS_READY;
    int          stall_run   = 0;

    logic [TB_TIME_BITS-1:0] now_us = '0;
    envelope_cfg_t           cfg_now;    // what the block holds, used to scale time steps

    blow_through_envelope_top uut (.*);

    blow_through_envelope_checker checker_i (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result back-pressure. A randomly picked mode, re-picked periodically: always
    // ready, a coin flip per cycle, or alternating random-length ready/stalled runs.
    always @(posedge aclk) begin
        if (cycle_count % 300 == 0)
            ready_mode = ready_mode_e'($urandom_range(0, 2));
        case (ready_mode)
            ALWAYS_READY: m_ready <= 1'b1;
            COIN_FLIP:    m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_run == 0) begin
                    stall_run = $urandom_range(1, 30);
                    m_ready <= ~m_ready;
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    // One tick transfer. Valid stays high across a burst; when a burst runs out
    // a random gap (often none) follows, so gaps land on every part of the
    // block's work. The caller drops valid once the stimulus stops.
    task automatic send_tick(input logic [TB_TIME_BITS-1:0] t,
                             input logic [PROX_W-1:0] prox,
                             input logic [CUE_W-1:0] cue);
        int gap;
        s_valid          <= 1'b1;
        s_now_us         <= t;
        s_proximity      <= prox;
        s_live_speed_cue <= cue;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Every tick yields one result, so matching counts means the block is idle.
    task automatic wait_results();
        while (results_seen < ticks_sent) @(posedge aclk);
    endtask

    // Writes all eight registers plus one index past the list, which the block
    // must ignore. With junk set, the bits above each register's width are
    // random and must be masked off.
    task automatic write_config(input envelope_cfg_t c, input bit junk);
        logic [CFG_IDX_W-1:0]  idx [REG_COUNT+1];
        logic [CFG_DATA_W-1:0] dat [REG_COUNT+1];
        logic [7:0]            hi;
        hi     = junk ? 8'($urandom) : 8'h00;
        idx[0] = REG_THRESHOLD;   dat[0] = {hi, c.thr};
        idx[1] = REG_SATURATION;  dat[1] = {hi, c.sat};
        idx[2] = REG_PEAK;        dat[2] = {hi, c.peak};
        idx[3] = REG_DIP;
        dat[3] = {junk ? hi[6:0] : {7{c.dip[DRIVE_W-1]}}, c.dip};
        idx[4] = REG_HOLD;        dat[4] = c.hold;
        idx[5] = REG_DIP_TIME;    dat[5] = c.dip_len;
        idx[6] = REG_RECOVER;     dat[6] = c.recover;
        idx[7] = REG_REFRACTORY;  dat[7] = c.refract;
        idx[8] = CFG_IDX_W'(REG_COUNT + $urandom_range(0, 7));
        dat[8] = CFG_DATA_W'($urandom);
        for (int i = 0; i <= REG_COUNT; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= dat[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_now = c;
    endtask

    // Register settings for each part of the random run; anything else gives
    // the reset values.
    function automatic envelope_cfg_t envelope_setting(input int which);
        envelope_cfg_t c;
        c.thr     = RST_THRESHOLD;
        c.sat     = RST_SATURATION;
        c.peak    = RST_PEAK;
        c.dip     = RST_DIP;
        c.hold    = RST_HOLD;
        c.dip_len = RST_DIP_TIME;
        c.recover = RST_RECOVER;
        c.refract = RST_REFRACTORY;
        case (which)
            0: begin   // widest ramp, full peak and full suction
                c.thr = '0;  c.sat = '1;  c.peak = '1;
                c.dip = -$signed({1'b0, 16'hFFFF});
                c.hold = 100;  c.dip_len = 100;  c.recover = 100;  c.refract = 500;
            end
            1: begin   // saturation equal to threshold, every segment zero length
                c.thr = 20000;  c.sat = 20000;  c.peak = '0;  c.dip = '0;
                c.hold = '0;  c.dip_len = '0;  c.recover = '0;  c.refract = '0;
            end
            2: begin   // saturation below threshold, shallow dip
                c.thr = '1;  c.sat = 1000;  c.peak = 30000;  c.dip = -17'sd1;
                c.hold    = DUR_W'($urandom_range(0, 50));
                c.dip_len = DUR_W'($urandom_range(1, 50));
                c.recover = DUR_W'($urandom_range(1, 50));
                c.refract = DUR_W'($urandom_range(0, 300));
            end
            3: begin
                c.thr     = PROX_W'($urandom_range(0, 30000));
                c.sat     = PROX_W'($urandom_range(int'(c.thr) + 1, 65535));
                c.peak    = CUE_W'($urandom);
                c.dip     = -$signed({1'b0, 16'($urandom)});
                c.hold    = DUR_W'($urandom_range(0, 2000));
                c.dip_len = DUR_W'($urandom_range(0, 2000));
                c.recover = DUR_W'($urandom_range(0, 2000));
                c.refract = DUR_W'($urandom_range(0, 8000));
            end
            4: begin   // longest segments
                c.peak = CUE_W'($urandom);
                c.dip  = -$signed({1'b0, 16'($urandom)});
                c.hold = '1;  c.dip_len = '1;  c.recover = '1;  c.refract = '1;
            end
            5: begin   // no hold, no recovery, longest lockout
                c.thr     = PROX_W'($urandom_range(0, 40000));
                c.sat     = PROX_W'($urandom_range(int'(c.thr), 65535));
                c.hold    = '0;
                c.dip_len = DUR_W'($urandom_range(1, 300));
                c.recover = '0;
                c.refract = '1;
            end
            6: begin   // no dip ramp, one-microsecond recovery, no lockout
                c.thr     = PROX_W'($urandom);
                c.sat     = PROX_W'($urandom);
                c.peak    = CUE_W'($urandom);
                c.hold    = DUR_W'($urandom_range(0, 500));
                c.dip_len = '0;
                c.recover = 1;
                c.refract = '0;
            end
            7: begin
                c.thr     = PROX_W'($urandom);
                c.sat     = PROX_W'($urandom);
                c.peak    = CUE_W'($urandom);
                c.dip     = -$signed({1'b0, 16'($urandom)});
                c.hold    = DUR_W'($urandom_range(0, 5000));
                c.dip_len = DUR_W'($urandom_range(0, 5000));
                c.recover = DUR_W'($urandom_range(0, 5000));
                c.refract = DUR_W'($urandom_range(0, 20000));
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        int               pick, seg_span, lockout_span;
        logic [PROX_W-1:0] prox;
        logic [CUE_W-1:0]  cue;

        cfg_now = envelope_setting(RESET_SETTING);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed ticks on the reset settings (ramp from 16384 to 32768,
        // peak 25600, dip -12800, segments 50 ms / 50 ms / 100 ms, lockout 1 s).
        send_tick(48'd0,       16'd0,     16'd0);      // idle, nothing
        send_tick(48'd10,      16'd16384, 16'hFFFF);   // exactly at threshold
        send_tick(48'd20,      16'd16385, 16'd1234);   // just above threshold
        send_tick(48'd30,      16'd32767, 16'd777);    // just below saturation
        send_tick(48'd1000,    16'd32768, 16'h5A5A);   // fires, latch at 1000
        send_tick(48'd50999,   16'd0,     16'h1111);   // last tick of the hold
        send_tick(48'd51000,   16'd0,     16'h2222);   // dip ramp starts
        send_tick(48'd76000,   16'hFFFF,  16'h3333);   // mid dip ramp
        send_tick(48'd101000,  16'd0,     16'h4444);   // recovery starts at the dip
        send_tick(48'd151000,  16'd0,     16'hFFFF);   // mid recovery
        send_tick(48'd200999,  16'd0,     16'hFFFF);   // last recovery tick
        send_tick(48'd201000,  16'd0,     16'hABCD);   // end of firing, locked out
        send_tick(48'd1000999, 16'd0,     16'd5);      // lockout not over yet
        send_tick(48'd1001000, 16'd16384, 16'd6);      // time up, proximity too high
        send_tick(48'd1001000, 16'd16383, 16'd7);      // re-arms
        send_tick(TIME_MAX,    16'hFFFF,  16'hFFFF);   // fires at the top of the clock
        send_tick(48'd0,       16'd0,     16'h00FF);   // clock wraps, still holding
        send_tick(TIME_MAX - 1, 16'd0,    16'hFF00);   // time goes back: reads as ended
        send_tick(TIME_MAX - 1, 16'd0,    16'h8001);   // lockout long gone, re-arms
        s_valid <= 1'b0;
        now_us = TIME_MAX - 1;

        // Random part: one block of ticks per register setting, written only
        // once every result of the previous block is out.
        for (int set = 0; set < SETTINGS_RUN; set++) begin
            wait_results();
            write_config(envelope_setting(set), set[0]);
            seg_span     = (int'(cfg_now.hold) + int'(cfg_now.dip_len)
                            + int'(cfg_now.recover)) / 8 + 1;
            lockout_span = int'(cfg_now.refract) / 4 + 1;
            for (int n = 0; n < TICKS_PER_SET; n++) begin
                // time step: mostly a fraction of the one-shot or of the lockout,
                // sometimes no step, now and then a jump, a step back or the wrap
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    now_us = now_us + TB_TIME_BITS'($urandom_range(0, seg_span));
                else if (pick < 85)
                    now_us = now_us + TB_TIME_BITS'($urandom_range(0, lockout_span));
                else if (pick >= 92 && pick < 96)
                    now_us = TB_TIME_BITS'({$urandom, $urandom});
                else if (pick >= 96 && pick < 99)
                    now_us = now_us - TB_TIME_BITS'($urandom_range(1, 1000));
                else if (pick == 99)
                    now_us = TIME_MAX - TB_TIME_BITS'($urandom_range(0, 2000));

                // proximity: below threshold, on the ramp, saturated, extremes
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    prox = PROX_W'($urandom_range(0, cfg_now.thr));
                else if (pick < 55)
                    prox = PROX_W'($urandom_range(cfg_now.thr, cfg_now.sat));
                else if (pick < 80)
                    prox = PROX_W'($urandom_range(cfg_now.sat, 65535));
                else if (pick < 85)
                    prox = '0;
                else if (pick < 90)
                    prox = '1;
                else
                    prox = PROX_W'($urandom);

                pick = $urandom_range(0, 9);
                cue  = (pick == 0) ? '1 : (pick == 1) ? '0 : CUE_W'($urandom);

                send_tick(now_us, prox, cue);
            end
            s_valid <= 1'b0;
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
